// File: design/stack_with_middle_delete_assert.svh
// ---------------------------------------------------------------------------
// stack_with_middle_delete assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef STACK_WITH_MIDDLE_DELETE_ASSERT_SVH
`define STACK_WITH_MIDDLE_DELETE_ASSERT_SVH

// same-cycle implication
`define SWMD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack_with_middle_delete assertion failed");

// next-cycle implication
`define SWMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack_with_middle_delete assertion failed");

`endif

// File: design/swmd_pkg.sv
// ---------------------------------------------------------------------------
// swmd_pkg
// shared constants and types of the stack with middle delete
// ---------------------------------------------------------------------------
`default_nettype none

package swmd_pkg;

  // fixed field widths
  localparam int WORD_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int DEPTH_DEFAULT = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELMID = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;    // every cell takes its upper neighbor
    logic remove;  // cells at or below the tap take their lower neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/swmd_cell.sv
// ---------------------------------------------------------------------------
// swmd_cell
// one stack position: holds a word, shifts with its neighbors, drives tap bus
// ---------------------------------------------------------------------------
`default_nettype none

module swmd_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  wire                         clk,
  input  wire  swmd_pkg::cell_ctrl_t  ctrl,
  input  wire  [IDX_W-1:0]            tap,
  input  wire  [swmd_pkg::WORD_W-1:0] above_data,
  input  wire  [swmd_pkg::WORD_W-1:0] below_data,
  output logic [swmd_pkg::WORD_W-1:0] data,
  output logic [swmd_pkg::WORD_W-1:0] sel_data
);
  import swmd_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              at_tap;
  logic              below_tap;

  // position compare against the tap
  assign at_tap    = (tap == IDX_W'(IDX));
  assign below_tap = (IDX_W'(IDX) >= tap);

  // shift selection
  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = above_data;
    end else if (ctrl.remove && below_tap) begin
      data_nxt = below_data;
    end
  end

  // word storage, no reset needed
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign sel_data = at_tap ? data_r : '0;

endmodule

`default_nettype wire

// File: design/stack_with_middle_delete.sv
// result strobed in the cycle after start is taken; one command per cycle.
// busy stays low, so a new command may be issued every cycle; the moving cells (all on a
// push, those at or below the tap on a removal) shift in the same cycle; the tap word is read through an or-bus.
// reset: synchronous active-low clears the entry count and the result strobe only;
// cell words are not cleared, there is no clearing pass.
// ---------------------------------------------------------------------------
// stack_with_middle_delete
// bounded lifo of signed words with push, pop and delete-middle commands
// ---------------------------------------------------------------------------
`default_nettype none

module stack_with_middle_delete #(
  parameter int DEPTH = swmd_pkg::DEPTH_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [swmd_pkg::CMD_W-1:0]         in_command,
  input  wire  signed [swmd_pkg::WORD_W-1:0] in_push_value,
  output logic                               out_valid,
  output logic signed [swmd_pkg::WORD_W-1:0] out_result_value,
  output logic [swmd_pkg::STAT_W-1:0]        out_status,
  output logic [swmd_pkg::COUNT_W-1:0]       out_entry_count
);
  import swmd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] result_r;
  logic [WORD_W-1:0] result_nxt;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;
  logic [EXT_W-1:0]  count_ext;

  logic              accept;
  logic              empty;
  logic              full;
  cell_ctrl_t        ctrl;
  logic [IDX_W-1:0]  tap;
  logic [IDX_W-1:0]  mid;
  logic [WORD_W-1:0] tap_data;

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] cell_sel  [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign mid    = IDX_W'(count_r >> 1);

  // or-bus over the cells: only the cell at the tap drives its word
  always_comb begin
    tap_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tap_data = tap_data | cell_sel[k];
    end
  end

  // command decode, next count and result
  always_comb begin
    ctrl       = '0;
    tap        = '0;
    count_nxt  = count_r;
    result_nxt = '0;
    status_nxt = ST_OK;
    case (in_command)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.push = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          result_nxt = '1;
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.remove = accept;
          result_nxt  = tap_data;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      CMD_DELMID: begin
        tap = mid;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.remove = accept;
          result_nxt  = tap_data;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // chain of cells, position 0 is the top
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] above;
    logic [WORD_W-1:0] below;
    if (k == 0) begin : g_top
      assign above = in_push_value;
    end else begin : g_mid
      assign above = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cell_data[k+1];
    end
    swmd_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .tap        (tap),
      .above_data (above),
      .below_data (below),
      .data       (cell_data[k]),
      .sel_data   (cell_sel[k])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
      status_r <= status_nxt;
    end
  end

  // count reported modulo 32
  assign count_ext        = EXT_W'(count_r);
  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;
  assign out_status       = status_r;
  assign out_entry_count  = count_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// File: design/swmd_checker.sv
// ---------------------------------------------------------------------------
// swmd_checker
// port-level assertions for the stack with middle delete, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none

`include "stack_with_middle_delete_assert.svh"

module swmd_checker #(
  parameter int DEPTH = swmd_pkg::DEPTH_DEFAULT
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                start,
  input wire                                busy,
  input wire  [swmd_pkg::CMD_W-1:0]         in_command,
  input wire  signed [swmd_pkg::WORD_W-1:0] in_push_value,
  input wire                                out_valid,
  input wire  signed [swmd_pkg::WORD_W-1:0] out_result_value,
  input wire  [swmd_pkg::STAT_W-1:0]        out_status,
  input wire  [swmd_pkg::COUNT_W-1:0]       out_entry_count
);
  import swmd_pkg::*;

  logic taken;
  logic unused_push;

  assign taken       = start && !busy;
  assign unused_push = ^in_push_value;

  // every taken request gives exactly one result in the next cycle
  `SWMD_ASSERT_NEXT(a_result_follows, taken, out_valid)
  `SWMD_ASSERT_IMPL(a_no_spurious, out_valid, $past(taken))

  // empty status only with an empty stack
  `SWMD_ASSERT_IMPL(a_empty_count, out_valid && out_status == ST_EMPTY,
                    out_entry_count == '0)

  // dropped push leaves a full stack and a zero word
  `SWMD_ASSERT_IMPL(a_full_drop, out_valid && out_status == ST_FULL,
                    out_entry_count == COUNT_W'(DEPTH) && out_result_value == 0 &&
                    unused_push == unused_push)

  // empty pop returns minus one
  `SWMD_ASSERT_IMPL(a_empty_pop, out_valid && out_status == ST_EMPTY &&
                    $past(in_command) == CMD_POP, out_result_value == -1)

endmodule

bind stack_with_middle_delete swmd_checker #(.DEPTH(DEPTH)) u_swmd_checker (.*);

`default_nettype wire
